>>> rtl/go_back_n_sender_window_assert.svh
// assertion macros for the go-back-n sender window
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH

// same-cycle implication
`define GBN_SW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GBN_SW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gbn_sw_pkg.sv
package gbn_sw_pkg;

	localparam int KIND_W     = 2;
	localparam int HANDLE_W   = 16;
	localparam int LEN_W      = 11;
	localparam int SEQ_W      = 4;
	localparam int WIN_W      = 4;
	localparam int TICK_W     = 16;
	localparam int DESC_W     = HANDLE_W + LEN_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int SEQ_SPACE_DEF   = 16;
	localparam int PAYLOAD_MAX_DEF = 1024;

	localparam logic [WIN_W-1:0]  WINDOW_RST  = 4'd10;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

	localparam logic [KIND_W-1:0] EV_OFFER = 2'd0;
	localparam logic [KIND_W-1:0] EV_ACK   = 2'd1;
	localparam logic [KIND_W-1:0] EV_TICK  = 2'd2;

	localparam logic [KIND_W-1:0] RK_TX     = 2'd0;
	localparam logic [KIND_W-1:0] RK_REFUSE = 2'd1;
	localparam logic [KIND_W-1:0] RK_STATUS = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_RESEND = 2'b10
	} state_t;

endpackage

>>> rtl/gbn_sw_if.sv
interface gbn_sw_evt_if;
	logic                              valid;
	logic                              ready;
	logic [gbn_sw_pkg::KIND_W-1:0]     kind;
	logic [gbn_sw_pkg::HANDLE_W-1:0]   pkt_handle;
	logic [gbn_sw_pkg::LEN_W-1:0]      pkt_length;
	logic [gbn_sw_pkg::SEQ_W-1:0]      ack_number;
	logic                              ack_intact;

	modport source (output valid, kind, pkt_handle, pkt_length, ack_number, ack_intact,
		input ready);
	modport sink (input valid, kind, pkt_handle, pkt_length, ack_number, ack_intact,
		output ready);
endinterface

interface gbn_sw_res_if;
	logic                              valid;
	logic                              ready;
	logic [gbn_sw_pkg::KIND_W-1:0]     result_kind;
	logic [gbn_sw_pkg::SEQ_W-1:0]      seq_number;
	logic [gbn_sw_pkg::HANDLE_W-1:0]   out_handle;
	logic [gbn_sw_pkg::LEN_W-1:0]      out_length;
	logic                              resent;
	logic [gbn_sw_pkg::SEQ_W-1:0]      window_base;
	logic                              transfer_done;
	logic                              last_of_run;

	modport source (output valid, result_kind, seq_number, out_handle, out_length, resent,
		window_base, transfer_done, last_of_run, input ready);
	modport sink (input valid, result_kind, seq_number, out_handle, out_length, resent,
		window_base, transfer_done, last_of_run, output ready);
endinterface

interface gbn_sw_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [gbn_sw_pkg::CFG_IDX_W-1:0]    reg_index;
	logic [gbn_sw_pkg::CFG_DATA_W-1:0]   wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

>>> rtl/go_back_n_sender_window.sv
// latency: an offer or ack result is registered and shown the cycle after the item is taken
// throughput: one item per cycle for offers, acks and ticks while the result slot drains
// a timeout run reads the descriptor memory (one registered read port) into a pending slot and then gives
// one retransmit per cycle while the result slot drains; input is held off until the run is read out
// reset (arst_n low): window 10, timeout 1000, base/next/timer/flags cleared, memory kept
module go_back_n_sender_window #(
	parameter int SEQ_SPACE   = gbn_sw_pkg::SEQ_SPACE_DEF,
	parameter int PAYLOAD_MAX = gbn_sw_pkg::PAYLOAD_MAX_DEF
) (
	input logic          clk,
	input logic          arst_n,
	gbn_sw_evt_if.sink   evt,
	gbn_sw_res_if.source res,
	gbn_sw_cfg_if.sink   cfg
);

	localparam int SW = $clog2(SEQ_SPACE);
	localparam int HW = gbn_sw_pkg::HANDLE_W;
	localparam int LW = gbn_sw_pkg::LEN_W;
	localparam int QW = gbn_sw_pkg::SEQ_W;
	localparam int TW = gbn_sw_pkg::TICK_W;
	localparam logic [SW:0]   SPACE   = (SW+1)'(SEQ_SPACE);
	localparam logic [SW-1:0] SEQ_TOP = SW'(SEQ_SPACE - 1);
	localparam logic [LW-1:0] LEN_CAP = LW'(PAYLOAD_MAX);
	localparam logic [TW-1:0] TICK_SAT = {TW{1'b1}};

	function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
		return (s == SEQ_TOP) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SW-1:0] seq_dist(input logic [SW-1:0] from,
		input logic [SW-1:0] to);
		logic [SW:0] d;
		d = {1'b0, to} - {1'b0, from};
		if (to < from) begin
			d = d + SPACE;
		end
		return d[SW-1:0];
	endfunction

	function automatic logic [QW-1:0] seq_port(input logic [SW-1:0] s);
		return QW'({{QW{1'b0}}, s});
	endfunction

	// control state
	gbn_sw_pkg::state_t state_q;
	logic [gbn_sw_pkg::WIN_W-1:0] window_q;
	logic [TW-1:0]                timeout_q;
	logic [SW-1:0]                base_q;
	logic [SW-1:0]                next_q;
	logic [TW-1:0]                timer_cnt_q;
	logic                         timer_run_q;
	logic                         final_q;
	logic                         done_q;
	logic [SW-1:0]                rd_ptr_q;
	logic [SW-1:0]                rem_q;
	logic                         pend_q;
	logic                         pend_last_q;
	logic [SW-1:0]                pend_seq_q;
	logic [gbn_sw_pkg::DESC_W-1:0] rd_data_q;

	// descriptor memory
	logic [gbn_sw_pkg::DESC_W-1:0] mem [SEQ_SPACE];

	// result register
	logic                          res_valid_q;
	logic [gbn_sw_pkg::KIND_W-1:0] res_kind_q;
	logic [QW-1:0]                 res_seq_q;
	logic [HW-1:0]                 res_handle_q;
	logic [LW-1:0]                 res_length_q;
	logic                          res_resent_q;
	logic [QW-1:0]                 res_base_q;
	logic                          res_done_q;
	logic                          res_last_q;

	logic          out_free;
	logic          in_ready;
	logic          acc;
	logic          move;
	logic          issue;
	logic          load_evt;
	logic [SW-1:0] outstanding;
	logic          full;
	logic          refuse;
	logic [LW-1:0] len_sat;
	logic [SW-1:0] ack_s;
	logic          ack_ok;
	logic [SW-1:0] new_base;
	logic          ack_done;
	logic [TW-1:0] cnt_inc;
	logic [TW-1:0] limit;
	logic          expire;

	assign out_free = !res_valid_q || res.ready;
	assign in_ready = (state_q == gbn_sw_pkg::ST_IDLE) && out_free;
	assign acc      = evt.valid && in_ready;
	assign move     = pend_q && out_free;
	assign issue    = (state_q == gbn_sw_pkg::ST_RESEND) && (rem_q != '0) && (!pend_q || move);
	assign load_evt = acc && ((evt.kind == gbn_sw_pkg::EV_OFFER) ||
		(evt.kind == gbn_sw_pkg::EV_ACK));

	always_comb begin
		outstanding = seq_dist(base_q, next_q);
		full    = (32'(outstanding) >= 32'(window_q)) || (32'(outstanding) >= SEQ_SPACE - 1);
		refuse  = final_q || full;
		len_sat = (32'(evt.pkt_length) > PAYLOAD_MAX) ? LEN_CAP : evt.pkt_length;
		ack_s   = SW'({{SW{1'b0}}, evt.ack_number});
		ack_ok  = evt.ack_intact && (32'(evt.ack_number) < SEQ_SPACE) &&
			(seq_dist(base_q, ack_s) < outstanding);
		new_base = seq_inc(ack_s);
		ack_done = ack_ok && final_q && (new_base == next_q);
		cnt_inc  = (timer_cnt_q != TICK_SAT) ? timer_cnt_q + 1'b1 : timer_cnt_q;
		limit    = (timeout_q == '0) ? TW'(1) : timeout_q;
		expire   = timer_run_q && (cnt_inc >= limit);
	end

	assign evt.ready = in_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= gbn_sw_pkg::WINDOW_RST;
			timeout_q <= gbn_sw_pkg::TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				gbn_sw_pkg::CFG_WINDOW: begin
					window_q <= cfg.wr_data[gbn_sw_pkg::WIN_W-1:0];
				end
				gbn_sw_pkg::CFG_TIMEOUT: begin
					timeout_q <= cfg.wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbn_sw_pkg::ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			timer_cnt_q <= '0;
			timer_run_q <= 1'b0;
			final_q     <= 1'b0;
			done_q      <= 1'b0;
			rd_ptr_q    <= '0;
			rem_q       <= '0;
			pend_q      <= 1'b0;
		end else begin
			if (acc) begin
				case (evt.kind)
					gbn_sw_pkg::EV_OFFER: begin
						if (!refuse) begin
							next_q <= seq_inc(next_q);
							if (len_sat == '0) begin
								final_q <= 1'b1;
							end
							if (outstanding == '0) begin
								timer_run_q <= 1'b1;
								timer_cnt_q <= '0;
							end
						end
					end
					gbn_sw_pkg::EV_ACK: begin
						if (ack_ok) begin
							base_q      <= new_base;
							timer_cnt_q <= '0;
							timer_run_q <= (new_base != next_q);
							if (ack_done) begin
								done_q <= 1'b1;
							end
						end
					end
					gbn_sw_pkg::EV_TICK: begin
						if (timer_run_q) begin
							if (expire) begin
								timer_cnt_q <= '0;
								if (outstanding != '0) begin
									state_q  <= gbn_sw_pkg::ST_RESEND;
									rd_ptr_q <= base_q;
									rem_q    <= outstanding;
								end
							end else begin
								timer_cnt_q <= cnt_inc;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (issue) begin
				rd_ptr_q <= seq_inc(rd_ptr_q);
				rem_q    <= rem_q - 1'b1;
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if ((state_q == gbn_sw_pkg::ST_RESEND) && (rem_q == '0) && (!pend_q || move)) begin
				state_q <= gbn_sw_pkg::ST_IDLE;
			end
		end
	end

	// memory port: write on accepted offer, read during a resend run
	always_ff @(posedge clk) begin
		if (acc && (evt.kind == gbn_sw_pkg::EV_OFFER) && !refuse) begin
			mem[next_q] <= {evt.pkt_handle, len_sat};
		end
		if (issue) begin
			rd_data_q   <= mem[rd_ptr_q];
			pend_seq_q  <= rd_ptr_q;
			pend_last_q <= (rem_q == SW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_evt || move) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_kind_q   <= gbn_sw_pkg::RK_TX;
			res_seq_q    <= seq_port(pend_seq_q);
			res_handle_q <= rd_data_q[gbn_sw_pkg::DESC_W-1:LW];
			res_length_q <= rd_data_q[LW-1:0];
			res_resent_q <= 1'b1;
			res_base_q   <= seq_port(base_q);
			res_done_q   <= done_q;
			res_last_q   <= pend_last_q;
		end else if (load_evt) begin
			res_resent_q <= 1'b0;
			res_last_q   <= 1'b1;
			if (evt.kind == gbn_sw_pkg::EV_OFFER) begin
				res_base_q <= seq_port(base_q);
				res_done_q <= done_q;
				res_seq_q  <= seq_port(next_q);
				if (refuse) begin
					res_kind_q   <= gbn_sw_pkg::RK_REFUSE;
					res_handle_q <= '0;
					res_length_q <= '0;
				end else begin
					res_kind_q   <= gbn_sw_pkg::RK_TX;
					res_handle_q <= evt.pkt_handle;
					res_length_q <= len_sat;
				end
			end else begin
				res_kind_q   <= gbn_sw_pkg::RK_STATUS;
				res_seq_q    <= evt.ack_number;
				res_handle_q <= '0;
				res_length_q <= '0;
				res_base_q   <= seq_port(ack_ok ? new_base : base_q);
				res_done_q   <= done_q || ack_done;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.result_kind   = res_kind_q;
	assign res.seq_number    = res_seq_q;
	assign res.out_handle    = res_handle_q;
	assign res.out_length    = res_length_q;
	assign res.resent        = res_resent_q;
	assign res.window_base   = res_base_q;
	assign res.transfer_done = res_done_q;
	assign res.last_of_run   = res_last_q;

endmodule

>>> rtl/gbn_sw_checker.sv
`include "go_back_n_sender_window_assert.svh"

module gbn_sw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic [gbn_sw_pkg::KIND_W-1:0]       result_kind,
	input logic [gbn_sw_pkg::SEQ_W-1:0]        seq_number,
	input logic [gbn_sw_pkg::HANDLE_W-1:0]     out_handle,
	input logic [gbn_sw_pkg::LEN_W-1:0]        out_length,
	input logic                                resent,
	input logic                                last_of_run
);

	// stalled result item holds
	`GBN_SW_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(result_kind) && $stable(seq_number) && $stable(out_handle) && $stable(out_length) && $stable(last_of_run), "result item changed while stalled")

	`GBN_SW_ASSERT_NOW(a_refuse_empty, res_valid && (result_kind == gbn_sw_pkg::RK_REFUSE), (out_handle == '0) && (out_length == '0) && !resent && last_of_run, "refused offer carries payload")

	`GBN_SW_ASSERT_NOW(a_resent_is_tx, res_valid && resent, result_kind == gbn_sw_pkg::RK_TX, "retransmit flagged on a non-transmit item")

	`GBN_SW_ASSERT_NOW(a_status_single, res_valid && (result_kind == gbn_sw_pkg::RK_STATUS), last_of_run && !resent && (out_handle == '0) && (out_length == '0), "ack status is not a single bare item")

endmodule

bind go_back_n_sender_window gbn_sw_checker u_gbn_sw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.result_kind (res.result_kind),
	.seq_number  (res.seq_number),
	.out_handle  (res.out_handle),
	.out_length  (res.out_length),
	.resent      (res.resent),
	.last_of_run (res.last_of_run)
);

>>> bench/go_back_n_sender_window_tb.sv
module go_back_n_sender_window_tb;
	import gbn_sw_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CFG_SETTLE   = 8;
	localparam int LEN_TOP      = (1 << LEN_W) - 1;

	localparam logic [KIND_W-1:0] EV_NONE = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] pkt_handle;
		logic [LEN_W-1:0]    pkt_length;
		logic [SEQ_W-1:0]    ack_number;
		logic                ack_intact;
	} event_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]   result_kind;
		logic [SEQ_W-1:0]    seq_number;
		logic [HANDLE_W-1:0] out_handle;
		logic [LEN_W-1:0]    out_length;
		logic                resent;
		logic [SEQ_W-1:0]    window_base;
		logic                transfer_done;
		logic                last_of_run;
	} tx_result_t;

	class sender_window_scoreboard;
		tx_result_t expected_results[$];
		int errors;
		logic [WIN_W-1:0]    wnd_size;
		logic [TICK_W-1:0]   timeout_lim;
		logic [SEQ_W-1:0]    base_seq;
		logic [SEQ_W-1:0]    next_seq;
		logic [HANDLE_W-1:0] held_handle [SEQ_SPACE_DEF];
		logic [LEN_W-1:0]    held_length [SEQ_SPACE_DEF];
		logic [TICK_W-1:0]   tick_count;
		bit timer_on;
		bit final_out;
		bit all_acked;

		function new();
			errors = 0;
			wnd_size = WINDOW_RST;
			timeout_lim = TIMEOUT_RST;
			base_seq = '0;
			next_seq = '0;
			tick_count = '0;
			timer_on = 0;
			final_out = 0;
			all_acked = 0;
		endfunction

		function logic [SEQ_W-1:0] in_flight();
			return next_seq - base_seq;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void add_result(logic [KIND_W-1:0] rk, logic [SEQ_W-1:0] seq,
			logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] len, logic rs, logic last);
			tx_result_t r;
			r.result_kind = rk;
			r.seq_number = seq;
			r.out_handle = h;
			r.out_length = len;
			r.resent = rs;
			r.window_base = base_seq;
			r.transfer_done = all_acked;
			r.last_of_run = last;
			expected_results.push_back(r);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_WINDOW) begin
				wnd_size = data[WIN_W-1:0];
			end else begin
				timeout_lim = data[TICK_W-1:0];
			end
		endfunction

		function void note_event(event_item_t it);
			logic [SEQ_W-1:0]  flight;
			logic [SEQ_W-1:0]  s;
			logic [SEQ_W-1:0]  lag;
			logic [LEN_W-1:0]  len;
			logic [TICK_W-1:0] lim;
			int cap;
			flight = in_flight();
			case (it.kind)
			EV_OFFER: begin
				cap = (wnd_size > SEQ_SPACE_DEF - 1) ? SEQ_SPACE_DEF - 1 : wnd_size;
				if (final_out || flight >= cap) begin
					add_result(RK_REFUSE, next_seq, '0, '0, 1'b0, 1'b1);
				end else begin
					len = (it.pkt_length > PAYLOAD_MAX_DEF) ? LEN_W'(PAYLOAD_MAX_DEF)
						: it.pkt_length;
					held_handle[next_seq] = it.pkt_handle;
					held_length[next_seq] = len;
					if (len == 0)
						final_out = 1;
					if (flight == 0) begin
						timer_on = 1;
						tick_count = '0;
					end
					s = next_seq;
					next_seq = next_seq + 1'b1;
					add_result(RK_TX, s, it.pkt_handle, len, 1'b0, 1'b1);
				end
			end
			EV_ACK: begin
				lag = it.ack_number - base_seq;
				if (it.ack_intact && lag < flight) begin
					base_seq = it.ack_number + 1'b1;
					tick_count = '0;
					timer_on = (base_seq != next_seq);
					if (final_out && base_seq == next_seq)
						all_acked = 1;
				end
				add_result(RK_STATUS, it.ack_number, '0, '0, 1'b0, 1'b1);
			end
			EV_TICK: begin
				if (timer_on) begin
					if (tick_count != '1)
						tick_count = tick_count + 1'b1;
					lim = (timeout_lim == 0) ? TICK_W'(1) : timeout_lim;
					if (tick_count >= lim) begin
						tick_count = '0;
						s = base_seq;
						for (int i = 0; i < flight; i++) begin
							add_result(RK_TX, s, held_handle[s], held_length[s], 1'b1,
								i == flight - 1);
							s = s + 1'b1;
						end
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void compare(string field, int unsigned e, int unsigned a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", field, e, a);
				errors++;
			end
		endfunction

		function void check_result(tx_result_t got);
			tx_result_t want;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: kind %0d seq %0d",
					got.result_kind, got.seq_number);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare("result_kind", want.result_kind, got.result_kind);
			compare("seq_number", want.seq_number, got.seq_number);
			compare("out_handle", want.out_handle, got.out_handle);
			compare("out_length", want.out_length, got.out_length);
			compare("resent", want.resent, got.resent);
			compare("window_base", want.window_base, got.window_base);
			compare("transfer_done", want.transfer_done, got.transfer_done);
			compare("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	gbn_sw_evt_if evt_ch();
	gbn_sw_res_if res_ch();
	gbn_sw_cfg_if cfg_ch();

	go_back_n_sender_window dut (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	sender_window_scoreboard sb;
	tx_result_t seen;
	bit hold_req;
	bit no_idle;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic event_item_t blank_item(logic [KIND_W-1:0] k);
		event_item_t it;
		it.kind = k;
		it.pkt_handle = HANDLE_W'($urandom_range(0, 65535));
		it.pkt_length = LEN_W'($urandom_range(0, LEN_TOP));
		it.ack_number = SEQ_W'($urandom_range(0, 15));
		it.ack_intact = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic event_item_t offer(logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] len);
		event_item_t it;
		it = blank_item(EV_OFFER);
		it.pkt_handle = h;
		it.pkt_length = len;
		return it;
	endfunction

	function automatic event_item_t ack(logic [SEQ_W-1:0] n, logic ok);
		event_item_t it;
		it = blank_item(EV_ACK);
		it.ack_number = n;
		it.ack_intact = ok;
		return it;
	endfunction

	function automatic event_item_t rand_item();
		event_item_t it;
		int pick;
		int flight;
		pick = $urandom_range(0, 99);
		flight = sb.in_flight();
		if (pick < 45) begin
			it = blank_item(EV_OFFER);
			case ($urandom_range(0, 9))
			0: it.pkt_length = LEN_W'($urandom_range(PAYLOAD_MAX_DEF + 1, LEN_TOP));
			1: it.pkt_length = LEN_W'(PAYLOAD_MAX_DEF);
			default: it.pkt_length = LEN_W'($urandom_range(1, PAYLOAD_MAX_DEF - 1));
			endcase
		end else if (pick < 72) begin
			it = blank_item(EV_ACK);
			it.ack_intact = 1'b1;
			if (flight > 0)
				it.ack_number = sb.base_seq + SEQ_W'($urandom_range(0, flight - 1));
		end else if (pick < 92) begin
			it = blank_item(EV_TICK);
		end else if (pick < 97) begin
			it = blank_item(EV_ACK);
			it.ack_intact = 1'b0;
		end else begin
			it = blank_item(EV_NONE);
		end
		return it;
	endfunction

	task automatic send_item(event_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.kind <= it.kind;
		evt_ch.pkt_handle <= it.pkt_handle;
		evt_ch.pkt_length <= it.pkt_length;
		evt_ch.ack_number <= it.ack_number;
		evt_ch.ack_intact <= it.ack_intact;
		do @(posedge clk); while (!evt_ch.ready);
		sb.note_event(it);
	endtask

	task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		evt_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, data);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] win, logic [CFG_DATA_W-1:0] tmo, int n,
		bit quiet, bit hold);
		program_reg(CFG_WINDOW, win);
		program_reg(CFG_TIMEOUT, tmo);
		no_idle = quiet;
		hold_req = hold;
		repeat (n) send_item(rand_item());
		no_idle = 0;
	endtask

	// result side
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = no_idle ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen.result_kind = res_ch.result_kind;
			seen.seq_number = res_ch.seq_number;
			seen.out_handle = res_ch.out_handle;
			seen.out_length = res_ch.out_length;
			seen.resent = res_ch.resent;
			seen.window_base = res_ch.window_base;
			seen.transfer_done = res_ch.transfer_done;
			seen.last_of_run = res_ch.last_of_run;
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		sb = new();
		stall_cycles = 0;
		hold_req = 0;
		no_idle = 0;
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.kind = EV_NONE;
		evt_ch.pkt_handle = '0;
		evt_ch.pkt_length = '0;
		evt_ch.ack_number = '0;
		evt_ch.ack_intact = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = CFG_WINDOW;
		cfg_ch.wr_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_reg(CFG_WINDOW, 16'd3);
		program_reg(CFG_TIMEOUT, 16'd2);
		send_item(blank_item(EV_TICK));
		send_item(ack(4'd0, 1'b1));
		send_item(offer(16'h0000, 11'd1024));
		send_item(offer(16'hFFFF, 11'd2047));
		send_item(offer(16'h1234, 11'd1));
		send_item(offer(16'h4321, 11'd50));
		send_item(blank_item(EV_NONE));
		send_item(ack(4'd1, 1'b0));
		send_item(ack(4'd15, 1'b1));
		send_item(blank_item(EV_TICK));
		send_item(blank_item(EV_TICK));
		send_item(ack(4'd0, 1'b1));
		send_item(ack(4'd2, 1'b1));
		send_item(blank_item(EV_TICK));
		send_item(offer(16'hAAAA, 11'h555));
		send_item(offer(16'h5555, 11'h2AA));
		send_item(blank_item(EV_TICK));
		send_item(blank_item(EV_TICK));
		send_item(ack(4'd4, 1'b1));

		run_phase(16'd15, 16'd4, 70, 1'b0, 1'b1);
		run_phase(16'd1, 16'd1, 50, 1'b0, 1'b0);
		run_phase(16'd8, 16'd65535, 50, 1'b1, 1'b0);
		run_phase(16'd15, 16'd0, 50, 1'b0, 1'b0);
		run_phase(16'hFFF0, 16'd3, 15, 1'b0, 1'b0);
		run_phase(16'd4, 16'd2, 60, 1'b0, 1'b0);
		run_phase(16'd15, 16'd3, 70, 1'b1, 1'b0);
		run_phase(16'd10, 16'd7, 50, 1'b0, 1'b0);

		// final packet, its retransmit and the closing ack
		program_reg(CFG_TIMEOUT, 16'd1);
		if (sb.in_flight() != 0)
			send_item(ack(sb.next_seq - 1'b1, 1'b1));
		send_item(offer(16'hFFFF, 11'd0));
		send_item(offer(16'h0F0F, 11'd100));
		send_item(blank_item(EV_TICK));
		send_item(ack(sb.next_seq - 1'b1, 1'b1));
		send_item(offer(16'h00FF, 11'd7));
		send_item(blank_item(EV_TICK));
		send_item(ack(sb.base_seq, 1'b1));
		evt_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
